### rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

    // one input item
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } t_hsv;

    // one result item
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // hue sextant
    typedef enum logic [2:0] {
        SEXT_0 = 3'd0,
        SEXT_1 = 3'd1,
        SEXT_2 = 3'd2,
        SEXT_3 = 3'd3,
        SEXT_4 = 3'd4,
        SEXT_5 = 3'd5
    } t_sext;

    // full scale and its square
    localparam logic [7:0]  FULL    = 8'd255;
    localparam logic [15:0] FULL_SQ = 16'd65025;

    // floor(2^32 / 65025), used as the reciprocal for the final divide
    localparam logic [16:0] RECIP       = 17'd66051;
    localparam int          RECIP_SHIFT = 32;

    // sextant boundaries on n = hue * 6
    localparam logic [10:0] N_SEXT_1 = 11'd255;
    localparam logic [10:0] N_SEXT_2 = 11'd510;
    localparam logic [10:0] N_SEXT_3 = 11'd765;
    localparam logic [10:0] N_SEXT_4 = 11'd1020;
    localparam logic [10:0] N_SEXT_5 = 11'd1275;
    localparam logic [10:0] N_WRAP   = 11'd1530;

endpackage

### rtl/hsv_to_rgb_pixel.sv
// HSV to RGB pixel converter, 8 bits per channel. One item enters per clock
// while the output is not stalled; the six register stages are sextant
// split with the p product, the p divide with the saturation products, the
// value products, the estimate and correction stages of the reciprocal divide
// by 65025, and the output register that selects the channels. A stall at the
// output freezes the whole pipeline, so nothing is lost or repeated. Hue 0..255
// spans a full turn; every channel is truncated toward zero.
module hsv_to_rgb_pixel (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  hsv2rgb_pkg::t_hsv       i_hsv,
    output logic                    o_valid,
    input  logic                    i_ready,
    output hsv2rgb_pkg::t_rgb       o_rgb
);

    logic                   c_en;

    // stage 1
    logic [10:0]            c_n;
    hsv2rgb_pkg::t_sext     c_sext;
    logic [10:0]            c_base;
    logic [15:0]            c_pnum;
    logic                   r_v1;
    hsv2rgb_pkg::t_sext     r_sext1;
    logic [7:0]             r_rem1;
    logic [7:0]             r_s1;
    logic [7:0]             r_bri1;
    logic [15:0]            r_pnum1;

    // stage 2
    logic [16:0]            c_psum;
    logic                   r_v2;
    hsv2rgb_pkg::t_sext     r_sext2;
    logic [7:0]             r_bri2;
    logic [7:0]             r_p2;
    logic [15:0]            r_sq2;
    logic [15:0]            r_st2;

    // stage 3
    logic                   r_v3;
    hsv2rgb_pkg::t_sext     r_sext3;
    logic [7:0]             r_bri3;
    logic [7:0]             r_p3;
    logic [23:0]            r_yq3;
    logic [23:0]            r_yt3;

    // stages 4 and 5 (divide)
    logic                   r_v4;
    hsv2rgb_pkg::t_sext     r_sext4;
    logic [7:0]             r_bri4;
    logic [7:0]             r_p4;
    logic                   r_v5;
    hsv2rgb_pkg::t_sext     r_sext5;
    logic [7:0]             r_bri5;
    logic [7:0]             r_p5;
    logic [7:0]             c_q;
    logic [7:0]             c_t;

    // output
    hsv2rgb_pkg::t_rgb      n_rgb;
    hsv2rgb_pkg::t_rgb      r_rgb;
    logic                   r_ovalid;

    // whole pipeline advances unless the output item is stalled
    assign c_en    = !r_ovalid || i_ready;
    assign o_ready = c_en;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_ovalid <= 1'b0;
        end else if (c_en) begin
            r_v1     <= i_valid;
            r_v2     <= r_v1;
            r_v3     <= r_v2;
            r_v4     <= r_v3;
            r_v5     <= r_v4;
            r_ovalid <= r_v5;
        end
    end

    // sextant and remainder of hue * 6 over 255, full turn folds to zero
    assign c_n = 11'({i_hsv.hue, 2'b00}) + 11'({i_hsv.hue, 1'b0});

    always_comb begin
        if (c_n >= hsv2rgb_pkg::N_WRAP) begin
            c_sext = hsv2rgb_pkg::SEXT_0;
            c_base = hsv2rgb_pkg::N_WRAP;
        end else if (c_n >= hsv2rgb_pkg::N_SEXT_5) begin
            c_sext = hsv2rgb_pkg::SEXT_5;
            c_base = hsv2rgb_pkg::N_SEXT_5;
        end else if (c_n >= hsv2rgb_pkg::N_SEXT_4) begin
            c_sext = hsv2rgb_pkg::SEXT_4;
            c_base = hsv2rgb_pkg::N_SEXT_4;
        end else if (c_n >= hsv2rgb_pkg::N_SEXT_3) begin
            c_sext = hsv2rgb_pkg::SEXT_3;
            c_base = hsv2rgb_pkg::N_SEXT_3;
        end else if (c_n >= hsv2rgb_pkg::N_SEXT_2) begin
            c_sext = hsv2rgb_pkg::SEXT_2;
            c_base = hsv2rgb_pkg::N_SEXT_2;
        end else if (c_n >= hsv2rgb_pkg::N_SEXT_1) begin
            c_sext = hsv2rgb_pkg::SEXT_1;
            c_base = hsv2rgb_pkg::N_SEXT_1;
        end else begin
            c_sext = hsv2rgb_pkg::SEXT_0;
            c_base = 11'd0;
        end
    end

    // p numerator v * (255 - s)
    assign c_pnum = 16'(i_hsv.brightness) * 16'(hsv2rgb_pkg::FULL - i_hsv.saturation);

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_sext1 <= c_sext;
            r_rem1  <= 8'(c_n - c_base);
            r_s1    <= i_hsv.saturation;
            r_bri1  <= i_hsv.brightness;
            r_pnum1 <= c_pnum;
        end
    end

    // p = pnum / 255, exact for numerators up to 255 * 255
    assign c_psum = 17'(r_pnum1) + 17'(r_pnum1[15:8]) + 17'd1;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_sext2 <= r_sext1;
            r_bri2  <= r_bri1;
            r_p2    <= c_psum[15:8];
            r_sq2   <= 16'(r_s1) * 16'(r_rem1);
            r_st2   <= 16'(r_s1) * 16'(hsv2rgb_pkg::FULL - r_rem1);
        end
    end

    // value products for q and t
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_sext3 <= r_sext2;
            r_bri3  <= r_bri2;
            r_p3    <= r_p2;
            r_yq3   <= 24'(r_bri2) * 24'(hsv2rgb_pkg::FULL_SQ - r_sq2);
            r_yt3   <= 24'(r_bri2) * 24'(hsv2rgb_pkg::FULL_SQ - r_st2);
        end
    end

    // divide both products by 65025
    hsv2rgb_div u_div_q (
        .i_clk (i_clk),
        .i_en  (c_en),
        .i_num (r_yq3),
        .o_quo (c_q)
    );

    hsv2rgb_div u_div_t (
        .i_clk (i_clk),
        .i_en  (c_en),
        .i_num (r_yt3),
        .o_quo (c_t)
    );

    // side data alongside the divider
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_sext4 <= r_sext3;
            r_bri4  <= r_bri3;
            r_p4    <= r_p3;
            r_sext5 <= r_sext4;
            r_bri5  <= r_bri4;
            r_p5    <= r_p4;
        end
    end

    // channel select by sextant
    always_comb begin
        case (r_sext5)
            hsv2rgb_pkg::SEXT_1: n_rgb = '{red: c_q,    green: r_bri5, blue: r_p5};
            hsv2rgb_pkg::SEXT_2: n_rgb = '{red: r_p5,   green: r_bri5, blue: c_t};
            hsv2rgb_pkg::SEXT_3: n_rgb = '{red: r_p5,   green: c_q,    blue: r_bri5};
            hsv2rgb_pkg::SEXT_4: n_rgb = '{red: c_t,    green: r_p5,   blue: r_bri5};
            hsv2rgb_pkg::SEXT_5: n_rgb = '{red: r_bri5, green: r_p5,   blue: c_q};
            default:             n_rgb = '{red: r_bri5, green: c_t,    blue: r_p5};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_ovalid;
    assign o_rgb   = r_rgb;

    // p never exceeds q or t
    a_p_lowest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_p5 <= c_q) && (r_p5 <= c_t))
        else $error("p channel above q or t");

    // q and t never exceed the value channel
    a_value_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (c_q <= r_bri5) && (c_t <= r_bri5))
        else $error("scaled channel above value");

    // a finished item reaches the output register when the pipe advances
    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v5 && c_en) |=> r_ovalid)
        else $error("item lost at output stage");

endmodule

### rtl/hsv2rgb_div.sv
// two-stage divide of a 24-bit product by 65025, quotient 0..255
module hsv2rgb_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [23:0] i_num,
    output logic [7:0]  o_quo
);

    logic [40:0] c_prod;
    logic [23:0] c_back;
    logic [23:0] c_diff;
    logic        c_inc;

    logic [23:0] r_num;
    logic [7:0]  r_q0;
    logic [7:0]  r_quo;

    // reciprocal estimate, low by at most one
    assign c_prod = 41'(i_num) * 41'(hsv2rgb_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= i_num;
            r_q0  <= c_prod[hsv2rgb_pkg::RECIP_SHIFT +: 8];
        end
    end

    // correct the estimate with one compare
    assign c_back = 24'(r_q0) * 24'(hsv2rgb_pkg::FULL_SQ);
    assign c_diff = r_num - c_back;
    assign c_inc  = (c_diff >= 24'(hsv2rgb_pkg::FULL_SQ));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= r_q0 + 8'(c_inc);
        end
    end

    assign o_quo = r_quo;

endmodule

### test/tb_hsv_to_rgb_pixel.sv
`timescale 1ns / 100ps

module tb_hsv_to_rgb_pixel;

    localparam int unsigned SCALE     = 255;
    localparam int unsigned SCALE_SQ  = 65025;
    localparam int          N_RANDOM  = 400;
    localparam int          IDLE_MAX  = 1000;
    localparam int          TAIL_WAIT = 20;

    // a pixel waiting to be sent; drain_first holds it back until the pipe is empty
    typedef struct {
        hsv2rgb_pkg::t_hsv px;
        bit                drain_first;
    } t_pixel_job;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              i_ready = 1'b0;
    hsv2rgb_pkg::t_hsv i_hsv   = '0;
    logic              o_ready;
    logic              o_valid;
    hsv2rgb_pkg::t_rgb o_rgb;

    t_pixel_job        pixel_q[$];
    hsv2rgb_pkg::t_rgb rgb_expected[$];

    logic hsv_taken   = 1'b0;
    int   idle_cycles = 0;
    int   errors      = 0;
    int   sent_cnt    = 0;
    int   checked_cnt = 0;
    int   burst_left  = 1;
    int   gap_left    = 0;
    int   ready_mode  = 0;
    int   mode_left   = 0;
    int   stall_left  = 0;

    hsv_to_rgb_pixel dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_hsv   (i_hsv),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rgb   (o_rgb)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // expected color of one pixel, truncated integer arithmetic
    function automatic hsv2rgb_pkg::t_rgb rgb_of_hsv(hsv2rgb_pkg::t_hsv px);
        int unsigned        n, rem, v, s, p_lvl, q_lvl, t_lvl;
        hsv2rgb_pkg::t_sext sext;
        hsv2rgb_pkg::t_rgb  c;
        v     = px.brightness;
        s     = px.saturation;
        n     = int'(px.hue) * 6;
        rem   = n % SCALE;
        // hue at full scale wraps to the first sextant
        sext  = (n / SCALE >= 6) ? hsv2rgb_pkg::SEXT_0 : hsv2rgb_pkg::t_sext'(n / SCALE);
        p_lvl = v * (SCALE - s) / SCALE;
        q_lvl = v * (SCALE_SQ - s * rem) / SCALE_SQ;
        t_lvl = v * (SCALE_SQ - s * (SCALE - rem)) / SCALE_SQ;
        case (sext)
            hsv2rgb_pkg::SEXT_1: begin
                c = '{8'(q_lvl), 8'(v), 8'(p_lvl)};
            end
            hsv2rgb_pkg::SEXT_2: begin
                c = '{8'(p_lvl), 8'(v), 8'(t_lvl)};
            end
            hsv2rgb_pkg::SEXT_3: begin
                c = '{8'(p_lvl), 8'(q_lvl), 8'(v)};
            end
            hsv2rgb_pkg::SEXT_4: begin
                c = '{8'(t_lvl), 8'(p_lvl), 8'(v)};
            end
            hsv2rgb_pkg::SEXT_5: begin
                c = '{8'(v), 8'(p_lvl), 8'(q_lvl)};
            end
            default: begin
                c = '{8'(v), 8'(t_lvl), 8'(p_lvl)};
            end
        endcase
        return c;
    endfunction

    // one line per failure, counted
    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("%0t ERROR %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic queue_pixel(int h, int s, int v, bit drain);
        t_pixel_job job;
        job.px          = '{8'(h), 8'(s), 8'(v)};
        job.drain_first = drain;
        pixel_q.push_back(job);
    endtask

    // mostly uniform, sometimes pinned to an edge value
    function automatic int rand_level();
        int edges[4] = '{0, 1, 254, 255};
        if ($urandom_range(0, 7) == 0) begin
            return edges[$urandom_range(0, 3)];
        end
        return $urandom_range(0, 255);
    endfunction

    // sender: bursts of items separated by random gaps
    always @(negedge i_clk) begin : driver
        t_pixel_job job;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || hsv_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (pixel_q.size() != 0 &&
                         !(pixel_q[0].drain_first && rgb_expected.size() != 0)) begin
                job     = pixel_q.pop_front();
                i_hsv   <= job.px;
                i_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: always ready, random stalls, or long stall runs, mode changes now and then
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(40, 150);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left != 0) begin
                    stall_left <= stall_left - 1;
                    i_ready    <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) begin
                        stall_left <= $urandom_range(1, 10);
                    end
                end
            end
        endcase
    end

    // monitor: record accepted pixels, check accepted colors
    always @(posedge i_clk) begin : monitor
        hsv2rgb_pkg::t_rgb want;
        hsv_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                rgb_expected.push_back(rgb_of_hsv(i_hsv));
                sent_cnt++;
            end
            if (o_valid && i_ready) begin
                if (rgb_expected.size() == 0) begin
                    report_mismatch("color with no pixel pending", int'(o_rgb), 0);
                end else begin
                    want = rgb_expected.pop_front();
                    checked_cnt++;
                    if (o_rgb.red != want.red) begin
                        report_mismatch("red", int'(o_rgb.red), int'(want.red));
                    end
                    if (o_rgb.green != want.green) begin
                        report_mismatch("green", int'(o_rgb.green), int'(want.green));
                    end
                    if (o_rgb.blue != want.blue) begin
                        report_mismatch("blue", int'(o_rgb.blue), int'(want.blue));
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial begin
        while (idle_cycles < IDLE_MAX) begin
            @(posedge i_clk);
        end
        $display("%0t no item moved for %0d cycles", $time, IDLE_MAX);
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        // sextant edges, hue wrap, saturation and brightness extremes
        queue_pixel(0, 0, 0, 1'b0);
        queue_pixel(0, 255, 255, 1'b0);
        queue_pixel(1, 255, 255, 1'b0);
        queue_pixel(42, 255, 255, 1'b0);
        queue_pixel(43, 255, 255, 1'b0);
        queue_pixel(85, 255, 255, 1'b0);
        queue_pixel(86, 77, 255, 1'b0);
        queue_pixel(127, 255, 255, 1'b0);
        queue_pixel(128, 255, 255, 1'b0);
        queue_pixel(170, 255, 255, 1'b0);
        queue_pixel(171, 200, 100, 1'b0);
        queue_pixel(212, 255, 255, 1'b0);
        queue_pixel(213, 255, 255, 1'b0);
        queue_pixel(254, 255, 255, 1'b0);
        queue_pixel(255, 255, 255, 1'b0);
        queue_pixel(255, 128, 200, 1'b0);
        queue_pixel(255, 0, 0, 1'b0);
        queue_pixel(100, 0, 255, 1'b0);
        queue_pixel(30, 255, 0, 1'b0);
        queue_pixel(200, 1, 254, 1'b0);
        queue_pixel(150, 254, 1, 1'b0);
        queue_pixel(64, 128, 128, 1'b0);

        // random pixels, pipe drained before every hundredth
        for (int k = 0; k < N_RANDOM; k++) begin
            queue_pixel($urandom_range(0, 255), rand_level(), rand_level(), (k % 100) == 0);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pixel_q.size() != 0 || i_valid || rgb_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_WAIT) @(posedge i_clk);

        foreach (rgb_expected[k]) begin
            report_mismatch("color never delivered", 0, int'(rgb_expected[k]));
        end

        $display("%0d pixels converted and %0d colors compared, covering all six hue",
                 sent_cnt, checked_cnt);
        $display("sectors, the hue wrap, and both ends of saturation and brightness");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
